>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/labs_pkg.sv
// ----------------------------------------------------------------------------
// labs_pkg
// Types and constants shared by the azimuth bin scan and its divider.
// ----------------------------------------------------------------------------
package labs_pkg;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned AzW     = 17;
  localparam int unsigned DistW   = 17;
  localparam int unsigned FracW   = 9;
  localparam int unsigned BinW    = 11;
  localparam int unsigned StartW  = 16;
  localparam int unsigned BwW     = 16;
  localparam int unsigned CountW  = 12;
  localparam int unsigned IntenW  = 8;
  localparam int unsigned DiffW   = 18;
  localparam int unsigned QuoW    = 17;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DivSteps = 17;
  localparam int unsigned DivCntW  = 5;

  localparam logic [DistW-1:0]  NoReturnDepth = 17'h1FF00;
  localparam logic [StartW-1:0] StartReset    = 16'hA600;
  localparam logic [BwW-1:0]    WidthReset    = 16'd128;
  localparam logic [CountW-1:0] CountReset    = 12'd360;

  typedef enum logic [CmdW-1:0] {
    CMD_POINT = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AZ_START  = 2'd0,
    CFG_BIN_WIDTH = 2'd1,
    CFG_BIN_COUNT = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic            start;
    logic [QuoW-1:0] dividend;
    logic [BwW-1:0]  divisor;
  } div_req_t;

endpackage

>>> src/lidar_azimuth_bin_scan.sv
// ----------------------------------------------------------------------------
// lidar_azimuth_bin_scan
// Lidar returns binned by azimuth into a flat scan of depth and intensity.
// ----------------------------------------------------------------------------
// A point request runs through one serial divider, which produces the bin
// quotient at one bit per cycle; the quotient is then picked up, the bin is
// written and the output register is loaded once the output is free. A read
// request passes through the registered read port of the scan memory. A
// clear request writes one bin per cycle over all MAX_BINS bins. After reset
// the same sweep runs over all bins with in_stall_o high; configuration
// writes are taken at any time. One request is in flight at a time; a
// finished result waits in the output register while the next request is
// accepted.
`include "assert_macros.svh"

module lidar_azimuth_bin_scan
  import labs_pkg::*;
#(
  parameter int unsigned MAX_BINS = 2048
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [StartW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CmdW-1:0]     cmd_i,
  input  logic signed [AzW-1:0]   azimuth_i,
  input  logic signed [DistW-1:0] distance_i,
  input  logic [FracW-1:0]    intensity_frac_i,
  input  logic [BinW-1:0]     read_bin_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BinW-1:0]     bin_index_o,
  output logic                clamped_o,
  output logic signed [DistW-1:0] depth_o,
  output logic [IntenW-1:0]   intensity_o
);

  localparam int unsigned AW      = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int unsigned EntryW  = DistW + IntenW;
  localparam int unsigned MaxCap  = (MAX_BINS > 4095) ? 4095 : MAX_BINS;
  localparam logic [CountW-1:0] MaxCapW = CountW'(MaxCap);
  localparam logic [AW-1:0]     LastAddr = AW'(MAX_BINS - 1);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIV  = 6'b000010,
    ST_WR   = 6'b000100,
    ST_RD   = 6'b001000,
    ST_CLR  = 6'b010000,
    ST_RESP = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [StartW-1:0] az_start_q;
  logic [BwW-1:0]    bin_width_q;
  logic [CountW-1:0] bin_count_q;

  logic              sweep_reply_q, sweep_reply_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;

  cmd_e              cmd_q;
  logic [DistW-1:0]  dist_q;
  logic [FracW-1:0]  frac_q;
  logic              neg_q;

  logic [BinW-1:0]   res_bin_q, res_bin_d;
  logic              res_clamp_q, res_clamp_d;
  logic [DistW-1:0]  res_depth_q, res_depth_d;
  logic [IntenW-1:0] res_inten_q, res_inten_d;

  logic              out_valid_q;
  logic [BinW-1:0]   out_bin_q;
  logic              out_clamp_q;
  logic [DistW-1:0]  out_depth_q;
  logic [IntenW-1:0] out_inten_q;

  logic [EntryW-1:0] scan_mem_q [MAX_BINS];
  logic [EntryW-1:0] rdata_q;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;

  logic              in_accept;
  logic              out_free;
  logic [DiffW-1:0]  diff;
  logic [DiffW-1:0]  mag;
  div_req_t          div_req;
  logic [QuoW-1:0]   div_quo;
  logic              div_done;

  logic [DistW-1:0]  inten_prod;
  logic [IntenW-1:0] inten_sat;
  logic [CountW-1:0] count_nz;
  logic [CountW-1:0] eff;
  logic              pt_clamp;
  logic [CountW-1:0] pt_bin;
  logic              rd_in_range;

  logic [BinW-1:0]   resp_bin;
  logic              resp_clamp;
  logic [DistW-1:0]  resp_depth;
  logic [IntenW-1:0] resp_inten;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_start_q  <= StartReset;
      bin_width_q <= WidthReset;
      bin_count_q <= CountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_AZ_START:  az_start_q  <= cfg_data_i;
        CFG_BIN_WIDTH: bin_width_q <= cfg_data_i;
        CFG_BIN_COUNT: bin_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign diff = {azimuth_i[AzW-1], azimuth_i}
              - {{(DiffW-StartW){az_start_q[StartW-1]}}, az_start_q};
  assign mag  = diff[DiffW-1] ? (~diff + 1'b1) : diff;

  assign div_req.start    = in_accept && (cmd_e'(cmd_i) == CMD_POINT);
  assign div_req.dividend = mag[QuoW-1:0];
  assign div_req.divisor  = bin_width_q;

  labs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .quotient_o (div_quo),
    .done_o     (div_done)
  );

  assign inten_prod = {frac_q, 8'b0} - {8'b0, frac_q};
  assign inten_sat  = inten_prod[16] ? 8'hFF : inten_prod[15:8];
  assign count_nz   = (bin_count_q == '0) ? CountW'(1) : bin_count_q;
  assign eff        = (count_nz > MaxCapW) ? MaxCapW : count_nz;
  assign pt_clamp   = (bin_width_q == '0) || (neg_q && (div_quo != '0))
                   || (div_quo >= {{(QuoW-CountW){1'b0}}, eff});
  assign pt_bin     = pt_clamp ? (eff - 1'b1) : div_quo[CountW-1:0];

  always_comb begin
    state_d       = state_q;
    sweep_reply_d = sweep_reply_q;
    clr_cnt_d     = clr_cnt_q;
    res_bin_d     = res_bin_q;
    res_clamp_d   = res_clamp_q;
    res_depth_d   = res_depth_q;
    res_inten_d   = res_inten_q;
    mem_we        = 1'b0;
    mem_waddr     = clr_cnt_q;
    mem_wdata     = {NoReturnDepth, 8'd0};
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_bin_d   = '0;
          res_clamp_d = 1'b0;
          res_depth_d = '0;
          res_inten_d = '0;
          case (cmd_e'(cmd_i))
            CMD_POINT: state_d = ST_DIV;
            CMD_READ: begin
              res_bin_d = read_bin_i;
              state_d   = ST_RD;
            end
            CMD_CLEAR: begin
              res_depth_d   = NoReturnDepth;
              sweep_reply_d = 1'b1;
              clr_cnt_d     = '0;
              state_d       = ST_CLR;
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_WR;
        end
      end
      ST_WR: begin
        mem_we      = 1'b1;
        mem_waddr   = AW'(pt_bin);
        mem_wdata   = {dist_q, inten_sat};
        res_bin_d   = pt_bin[BinW-1:0];
        res_clamp_d = pt_clamp;
        res_depth_d = dist_q;
        res_inten_d = inten_sat;
        state_d     = ST_RESP;
      end
      ST_RD: state_d = ST_RESP;
      ST_CLR: begin
        mem_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastAddr) begin
          clr_cnt_d     = '0;
          sweep_reply_d = 1'b0;
          state_d       = sweep_reply_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLR;
      sweep_reply_q <= 1'b0;
      clr_cnt_q     <= '0;
    end else begin
      state_q       <= state_d;
      sweep_reply_q <= sweep_reply_d;
      clr_cnt_q     <= clr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      dist_q <= distance_i;
      frac_q <= intensity_frac_i;
      neg_q  <= diff[DiffW-1];
    end
    res_bin_q   <= res_bin_d;
    res_clamp_q <= res_clamp_d;
    res_depth_q <= res_depth_d;
    res_inten_q <= res_inten_d;
  end

  assign mem_raddr = AW'(res_bin_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      scan_mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= scan_mem_q[mem_raddr];
  end

  assign rd_in_range = (32'(res_bin_q) < MAX_BINS);

  always_comb begin
    resp_bin   = res_bin_q;
    resp_clamp = res_clamp_q;
    resp_depth = res_depth_q;
    resp_inten = res_inten_q;
    if (cmd_q == CMD_READ) begin
      resp_clamp = 1'b0;
      resp_depth = rd_in_range ? rdata_q[EntryW-1:IntenW] : NoReturnDepth;
      resp_inten = rd_in_range ? rdata_q[IntenW-1:0] : 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_RESP && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RESP && out_free) begin
      out_bin_q   <= resp_bin;
      out_clamp_q <= resp_clamp;
      out_depth_q <= resp_depth;
      out_inten_q <= resp_inten;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_index_o = out_bin_q;
  assign clamped_o   = out_clamp_q;
  assign depth_o     = out_depth_q;
  assign intensity_o = out_inten_q;

  `ASSERT_IMP(a_wr_after_div, state_q == ST_WR, $past(div_done), "bin write without quotient")
  `ASSERT_IMP(a_sweep_from_zero, $rose(state_q == ST_CLR), clr_cnt_q == '0, "sweep not at bin 0")
  `ASSERT_IMP(a_out_from_resp, $rose(out_valid_q), $past(state_q) == ST_RESP, "result not from resp")
  `ASSERT_NEXT(a_resp_delivers, state_q == ST_RESP && !out_valid_q, out_valid_q, "result lost")

endmodule

>>> src/labs_div.sv
// ----------------------------------------------------------------------------
// labs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module labs_div
  import labs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_req_t        req_i,
  output logic [QuoW-1:0] quotient_o,
  output logic            done_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DivCntW-1:0]  cnt_q, cnt_d;
  logic [QuoW-1:0]     num_q, num_d;
  logic [BwW-1:0]      rem_q, rem_d;
  logic [BwW-1:0]      dsr_q, dsr_d;
  logic [BwW:0]        trial;
  logic [BwW:0]        diff;
  logic                ge;

  assign trial = {rem_q, num_q[QuoW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivSteps - 1);
      num_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      num_d = {num_q[QuoW-2:0], ge};
      rem_d = ge ? diff[BwW-1:0] : trial[BwW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = num_q;
  assign done_o     = done_q;

endmodule

>>> dv/tb_lidar_azimuth_bin_scan.sv
// ----------------------------------------------------------------------------
// tb_lidar_azimuth_bin_scan
// Self-checking bench for the azimuth bin scan. A behavioral scan memory
// predicts every result; requests go out in random bursts while the result
// side stalls in modes of its own. Directed cases cover field extremes, all
// commands, clamping and odd register values; random phases then sweep a
// range of register settings with mostly in-range and edge-of-range points.
// ----------------------------------------------------------------------------
module tb_lidar_azimuth_bin_scan;
  import labs_pkg::*;

  localparam int unsigned ScanBins    = 2048;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned IdleLimit   = 20000;
  localparam int unsigned PhaseCount  = 9;
  localparam int unsigned PhaseReqs   = 100;

  typedef struct {
    cmd_e                    cmd;
    logic signed [AzW-1:0]   azimuth;
    logic signed [DistW-1:0] distance;
    logic [FracW-1:0]        frac;
    logic [BinW-1:0]         read_bin;
  } scan_req_t;

  typedef struct {
    logic [BinW-1:0]         bin_index;
    logic                    clamped;
    logic signed [DistW-1:0] depth;
    logic [IntenW-1:0]       intensity;
  } bin_result_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CfgIdxW-1:0]      cfg_index_i = '0;
  logic [StartW-1:0]       cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [CmdW-1:0]         cmd_i = '0;
  logic signed [AzW-1:0]   azimuth_i = '0;
  logic signed [DistW-1:0] distance_i = '0;
  logic [FracW-1:0]        intensity_frac_i = '0;
  logic [BinW-1:0]         read_bin_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic [BinW-1:0]         bin_index_o;
  logic                    clamped_o;
  logic signed [DistW-1:0] depth_o;
  logic [IntenW-1:0]       intensity_o;

  lidar_azimuth_bin_scan #(.MAX_BINS(ScanBins)) uut (.*);

  logic signed [DistW-1:0] depth_mem [ScanBins];
  logic [IntenW-1:0]       inten_mem [ScanBins];
  logic signed [StartW-1:0] az_start;
  logic [BwW-1:0]          bin_width;
  logic [CountW-1:0]       bin_count;

  bin_result_t       expected_bins_q[$];
  logic [BinW-1:0]   recent_bins[$];
  bit                valid_held = 1'b0;
  int unsigned       burst_left = 0;
  int unsigned       n_errors = 0, n_results = 0, n_settings = 0;
  int unsigned       n_points = 0, n_clamped = 0, n_reads = 0, n_clears = 0, n_idle_cmds = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       stall_mode = 0, stall_left = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void clear_scan();
    for (int i = 0; i < ScanBins; i++) begin
      depth_mem[i] = NoReturnDepth;
      inten_mem[i] = '0;
    end
  endfunction

  function automatic int active_bins();
    int eff;
    eff = (bin_count == 0) ? 1 : int'(bin_count);
    if (eff > int'(ScanBins)) eff = ScanBins;
    return eff;
  endfunction

  function automatic bin_result_t scan_update(scan_req_t r);
    bin_result_t res;
    int diff, mag, quo, eff, level, bin;
    res = '{default: '0};
    case (r.cmd)
      CMD_POINT: begin
        eff = active_bins();
        level = (int'(r.frac) * 255) >> 8;
        if (level > 255) level = 255;
        diff = int'(r.azimuth) - int'(az_start);
        mag = (diff < 0) ? -diff : diff;
        res.clamped = 1'b1;
        bin = eff - 1;
        if (bin_width != 0) begin
          quo = mag / int'(bin_width);
          if (!((diff < 0 && quo > 0) || quo >= eff)) begin
            res.clamped = 1'b0;
            bin = quo;
          end
        end
        depth_mem[bin] = r.distance;
        inten_mem[bin] = IntenW'(level);
        res.bin_index = BinW'(bin);
        res.depth = r.distance;
        res.intensity = IntenW'(level);
      end
      CMD_READ: begin
        res.bin_index = r.read_bin;
        res.depth = depth_mem[r.read_bin];
        res.intensity = inten_mem[r.read_bin];
      end
      CMD_CLEAR: begin
        clear_scan();
        res.depth = NoReturnDepth;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic scan_req_t make_req(cmd_e c, int az = 0, int range_val = 0, int frac = 0,
                                         int rbin = 0);
    scan_req_t r;
    r.cmd = c;
    r.azimuth = AzW'(az);
    r.distance = DistW'(range_val);
    r.frac = FracW'(frac);
    r.read_bin = BinW'(rbin);
    return r;
  endfunction

  function automatic scan_req_t random_req();
    scan_req_t r;
    int eff, pick, k, w, base;
    r = make_req(CMD_POINT, $urandom, $urandom, $urandom_range(0, 256), $urandom);
    eff = active_bins();
    w = int'(bin_width);
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      r.cmd = CMD_CLEAR;
    end else if (pick < 5) begin
      r.cmd = CMD_NONE;
    end else if (pick < 35) begin
      r.cmd = CMD_READ;
      pick = $urandom_range(0, 2);
      if (pick == 0 && recent_bins.size() != 0)
        r.read_bin = recent_bins[$urandom_range(0, recent_bins.size() - 1)];
      else if (pick == 1)
        r.read_bin = BinW'($urandom_range(0, eff - 1));
    end else begin
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, eff - 1);
      base = int'(az_start);
      if (pick < 70) begin
        base += k * w;
        if (w > 0) base += int'($urandom_range(0, w - 1));
        r.azimuth = AzW'(base);
      end else if (pick < 88) begin
        case ($urandom_range(0, 5))
          0: base -= 1;
          1: base -= w;
          2: base -= w + 1;
          3: base += eff * w;
          4: base += eff * w - 1;
          default: base += (eff - 1) * w;
        endcase
        r.azimuth = AzW'(base);
      end
      if ($urandom_range(0, 9) == 0) r.distance = NoReturnDepth;
      if ($urandom_range(0, 7) == 0) r.frac = FracW'($urandom);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int want, int got);
    n_errors++;
    if (n_errors <= 30)
      $display("Mismatch on result %0d, %s: expected %0d, got %0d", n_results, what, want, got);
  endtask

  task automatic send_req(scan_req_t r);
    bin_result_t res;
    in_valid_i <= 1'b1;
    valid_held = 1'b1;
    cmd_i <= r.cmd;
    azimuth_i <= r.azimuth;
    distance_i <= r.distance;
    intensity_frac_i <= r.frac;
    read_bin_i <= r.read_bin;
    do @(posedge clk_i); while (in_stall_o);
    res = scan_update(r);
    expected_bins_q.push_back(res);
    case (r.cmd)
      CMD_POINT: begin
        n_points++;
        if (res.clamped) n_clamped++;
        recent_bins.push_back(res.bin_index);
        if (recent_bins.size() > 32) void'(recent_bins.pop_front());
      end
      CMD_READ: n_reads++;
      CMD_CLEAR: n_clears++;
      default: n_idle_cmds++;
    endcase
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_scan();
    if (valid_held) begin
      in_valid_i <= 1'b0;
      valid_held = 1'b0;
    end
    while (expected_bins_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [StartW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_AZ_START:  az_start = value;
      CFG_BIN_WIDTH: bin_width = value;
      CFG_BIN_COUNT: bin_count = value[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [StartW-1:0] start, logic [StartW-1:0] width,
                                logic [StartW-1:0] count, bit poke_unused);
    drain_scan();
    if (poke_unused || $urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 16'($urandom));
    write_reg(CFG_AZ_START, start);
    write_reg(CFG_BIN_WIDTH, width);
    write_reg(CFG_BIN_COUNT, count);
    cfg_valid_i <= 1'b0;
    n_settings++;
  endtask

  task automatic test_directed_fields();
    send_req(make_req(CMD_POINT, -23040, 65535, 0));
    send_req(make_req(CMD_POINT, -23041, -256, 256));
    send_req(make_req(CMD_POINT, -23168, -65536, 511));
    send_req(make_req(CMD_POINT, 23040, 0, 255));
    send_req(make_req(CMD_POINT, 23039, 12345, 1));
    send_req(make_req(CMD_POINT, -65536, 1000, 128));
    send_req(make_req(CMD_POINT, 65535, 4660, 200));
    send_req(make_req(CMD_POINT, -22912, 77, 64));
    send_req(make_req(CMD_READ, 0, 0, 0, 0));
    send_req(make_req(CMD_READ, 0, 0, 0, 1));
    send_req(make_req(CMD_READ, 0, 0, 0, 359));
    send_req(make_req(CMD_READ, -1, -1, 511, 2047));
    send_req(make_req(CMD_NONE, -1, -1, 511, 2047));
    send_req(make_req(CMD_CLEAR, -1, -1, 511, 2047));
    send_req(make_req(CMD_READ, 0, 0, 0, 0));
    send_req(make_req(CMD_READ, 0, 0, 0, 359));
  endtask

  task automatic test_special_settings();
    apply_settings(StartReset, 16'd0, CountReset, 1'b1);
    send_req(make_req(CMD_POINT, -23040, 500, 100));
    apply_settings(StartReset, WidthReset, 16'h0000, 1'b0);
    send_req(make_req(CMD_POINT, -23040, 600, 50));
    send_req(make_req(CMD_POINT, 0, 700, 30));
    apply_settings(16'h0000, 16'd1, 16'h0FFF, 1'b0);
    send_req(make_req(CMD_POINT, 2047, 800, 20));
    send_req(make_req(CMD_POINT, 3000, 900, 10));
    send_req(make_req(CMD_READ, 0, 0, 0, 2047));
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: apply_settings(StartReset, WidthReset, CountReset, 1'b0);
        1: apply_settings(16'h0000, 16'd1, 16'd2048, 1'b0);
        2: apply_settings(16'h8000, 16'hFFFF, 16'd1, 1'b0);
        3: apply_settings(16'h7FFF, 16'd46080, 16'hFFFF, 1'b0);
        4: apply_settings(StartReset, 16'd0, 16'd180, 1'b0);
        5: apply_settings(16'hFC00, 16'd7, 16'h0000, 1'b0);
        default: apply_settings(16'($urandom), 16'($urandom_range(1, 600)),
                                {4'($urandom), 12'($urandom_range(1, 2048))}, 1'b0);
      endcase
      for (int i = 0; i < PhaseReqs; i++) send_req(random_req());
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 1) != 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    bin_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (expected_bins_q.size() == 0) begin
        report_mismatch("result with nothing pending, bin_index", -1, int'(bin_index_o));
      end else begin
        want = expected_bins_q.pop_front();
        if (bin_index_o !== want.bin_index)
          report_mismatch("bin_index", int'(want.bin_index), int'(bin_index_o));
        if (clamped_o !== want.clamped)
          report_mismatch("clamped", int'(want.clamped), int'(clamped_o));
        if (depth_o !== want.depth)
          report_mismatch("depth", int'(want.depth), int'(depth_o));
        if (intensity_o !== want.intensity)
          report_mismatch("intensity", int'(want.intensity), int'(intensity_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Timeout after %0d cycles without a handshake, %0d results outstanding",
               idle_cycles, expected_bins_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clear_scan();
    az_start = StartReset;
    bin_width = WidthReset;
    bin_count = CountReset;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_fields();
    test_special_settings();
    test_random_phases();
    drain_scan();
    repeat (40) @(posedge clk_i);
    $display("Requests: %0d points (%0d clamped), %0d reads, %0d clears, %0d unused codes",
             n_points, n_clamped, n_reads, n_clears, n_idle_cmds);
    $display("Register settings: %0d, results checked: %0d, mismatches: %0d",
             n_settings, n_results, n_errors);
    if (n_errors == 0 && expected_bins_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
